/* design/cbps_pkg.sv */
// Shared constants, types and control structs of the cubic Bezier path sampler.
package cbps_pkg;

  localparam int CoordW        = 32;
  localparam int StepW         = 16;
  // The Bernstein weights carry three parameter factors, so they are Q0.48.
  localparam int FracW         = 3 * StepW;
  localparam int TdataW        = 3 * CoordW + StepW;
  localparam int DefCoordBits  = 32;
  localparam int DefMaxSamples = 64;
  localparam int QueueDepth    = 2;

  // Passes of the bit-serial setup multiplier.
  localparam logic [1:0] PassFirst  = 2'd0;
  localparam logic [1:0] PassSecond = 2'd1;
  localparam logic [1:0] PassLast   = 2'd2;

  typedef enum logic [1:0] {
    KIND_ANCHOR,
    KIND_HANDLE1,
    KIND_HANDLE2,
    KIND_SEGMENT
  } kind_e;

  typedef struct packed {
    logic       prep;
    logic       mul;
    logic [1:0] pass;
    logic       pass_end;
    logic       step_bit;
    logic       fin1;
    logic       fin2;
    logic       advance;
  } lane_ctrl_t;

endpackage

/* design/cubic_bezier_path_sampler.sv */
// Top level of the cubic Bezier path sampler: front, queue and back tied together.
// A segment occupies the back end for the bit-serial setup multiply (three 16-bit passes), then
// for its n samples (n <= MAX_SAMPLES), one per cycle while the output is not stalled. Anchor and
// handle points are taken while the back end is idle; the two-entry queue absorbs them.
// Reset is asynchronous and active low; it empties the queue and clears the path phase.
module cubic_bezier_path_sampler #(
  parameter int COORD_BITS  = cbps_pkg::DefCoordBits,
  parameter int MAX_SAMPLES = cbps_pkg::DefMaxSamples
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // coord_x [31:0], coord_y [63:32], coord_z [95:64], t_step [111:96]
  input  logic [cbps_pkg::TdataW-1:0] s_axis_tdata,
  // path_start
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], sample_t [111:96]
  output logic [cbps_pkg::TdataW-1:0] m_axis_tdata,
  // last_sample
  output logic                        m_axis_tlast
);
  import cbps_pkg::*;

  localparam int HeldBits = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam int EntryW   = StepW + 3 * HeldBits + $bits(kind_e);

  logic                  push, full, pop, q_valid;
  kind_e                 front_kind;
  logic [3*HeldBits-1:0] front_point;
  logic [StepW-1:0]      front_step;
  logic [EntryW-1:0]     q_in, q_out;

  cbps_front #(
    .HELD_BITS (HeldBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_kind_o   (front_kind),
    .q_point_o  (front_point),
    .q_step_o   (front_step)
  );

  assign q_in = {front_step, front_point, front_kind};

  cbps_queue #(
    .WIDTH (EntryW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  cbps_back #(
    .HELD_BITS   (HeldBits),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (pop),
    .q_kind_i   (kind_e'(q_out[$bits(kind_e)-1:0])),
    .q_point_i  (q_out[$bits(kind_e) +: 3*HeldBits]),
    .q_step_i   (q_out[EntryW-1 -: StepW]),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

/* design/cbps_queue.sv */
// Small first-in first-out queue between the front and the back of the sampler.
module cbps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/cbps_front.sv */
// Input side: accepts control points, tracks the segment phase and classifies each point.
module cbps_front #(
  parameter int HELD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [cbps_pkg::TdataW-1:0]  s_tdata_i,
  input  logic                         s_tuser_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output cbps_pkg::kind_e              q_kind_o,
  output logic [3*HELD_BITS-1:0]       q_point_o,
  output logic [cbps_pkg::StepW-1:0]   q_step_o
);
  import cbps_pkg::*;

  localparam logic [1:0] PhNone    = 2'd0;
  localparam logic [1:0] PhHandle1 = 2'd1;
  localparam logic [1:0] PhHandle2 = 2'd2;
  localparam logic [1:0] PhAnchor  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic       active_q, active_d;
  logic       accept, keep;
  kind_e      kind;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    keep     = 1'b0;
    kind     = KIND_ANCHOR;
    if (s_tuser_i) begin
      // A path start always restarts the phase, dropping any open segment.
      keep     = 1'b1;
      kind     = KIND_ANCHOR;
      phase_d  = PhHandle1;
      active_d = 1'b1;
    end else if (active_q) begin
      unique case (phase_q)
        PhHandle1: begin
          keep    = 1'b1;
          kind    = KIND_HANDLE1;
          phase_d = PhHandle2;
        end
        PhHandle2: begin
          keep    = 1'b1;
          kind    = KIND_HANDLE2;
          phase_d = PhAnchor;
        end
        PhAnchor: begin
          keep    = 1'b1;
          kind    = KIND_SEGMENT;
          phase_d = PhHandle1;
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhNone;
      active_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      active_q <= active_d;
    end
  end

  // Coordinates are held at HELD_BITS: the low bits, read as a signed value.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_point_o[c*HELD_BITS +: HELD_BITS] = s_tdata_i[c*CoordW +: HELD_BITS];
    end
  end

  assign q_push_o = accept && keep;
  assign q_kind_o = kind;
  assign q_step_o = s_tdata_i[3*CoordW +: StepW];

endmodule

/* design/cbps_lane.sv */
// One coordinate's datapath: setup of the forward differences and the per-sample update.
module cbps_lane #(
  parameter int HELD_BITS = 32
) (
  input  logic                        clk_i,
  input  cbps_pkg::lane_ctrl_t        ctrl_i,
  input  logic signed [HELD_BITS-1:0] anchor_i,
  input  logic signed [HELD_BITS-1:0] exit_i,
  input  logic signed [HELD_BITS-1:0] entry_i,
  input  logic signed [HELD_BITS-1:0] next_i,
  output logic signed [HELD_BITS-1:0] pos_o
);
  import cbps_pkg::*;

  // The blend is exact modulo 2^W; its top HELD_BITS bits are the rounded position.
  localparam int W  = HELD_BITS + FracW;
  localparam int EW = HELD_BITS + 4;

  logic signed [EW-1:0] a_e, h1_e, h2_e, b_e;
  logic signed [EW-1:0] d_ha, d_c, d_hh;
  logic signed [EW-1:0] e1, e2, e3;
  logic [W-1:0] s_q, d1_q, d2_q, d3_q;
  logic [W-1:0] src_a_q, src_b_q, src_g_q;
  logic [W-1:0] a_n, b_n, g_n;

  // Power-basis coefficients of the curve in t:
  // S = 2^48*A + 2^32*e1*t + 2^16*e2*t^2 + e3*t^3.
  assign a_e  = EW'(anchor_i);
  assign h1_e = EW'(exit_i);
  assign h2_e = EW'(entry_i);
  assign b_e  = EW'(next_i);
  assign d_ha = h1_e - a_e;
  assign e1   = d_ha + (d_ha <<< 1);
  assign d_c  = a_e - (h1_e <<< 1) + h2_e;
  assign e2   = d_c + (d_c <<< 1);
  assign d_hh = h1_e - h2_e;
  assign e3   = b_e - a_e + d_hh + (d_hh <<< 1);

  // Shift-and-add multiply by the step, most significant bit first.
  assign a_n = (d1_q << 1) + (ctrl_i.step_bit ? src_a_q : '0);
  assign b_n = (d2_q << 1) + (ctrl_i.step_bit ? src_b_q : '0);
  assign g_n = (d3_q << 1) + (ctrl_i.step_bit ? src_g_q : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prep) begin
      // The half LSB for rounding rides in the running sum from the start.
      s_q     <= {anchor_i, 1'b1, {(FracW-1){1'b0}}};
      src_a_q <= W'(e1);
      src_b_q <= W'(e2);
      src_g_q <= W'(e3);
      d1_q    <= '0;
      d2_q    <= '0;
      d3_q    <= '0;
    end else if (ctrl_i.mul) begin
      if (ctrl_i.pass == PassFirst) begin
        d1_q <= a_n;
      end
      if (ctrl_i.pass == PassFirst && ctrl_i.pass_end) begin
        src_b_q <= b_n;
        d2_q    <= '0;
      end else if (ctrl_i.pass != PassLast) begin
        d2_q <= b_n;
      end
      if (ctrl_i.pass_end && ctrl_i.pass != PassLast) begin
        src_g_q <= g_n;
        d3_q    <= '0;
      end else begin
        d3_q <= g_n;
      end
    end else if (ctrl_i.fin1) begin
      // alpha + beta, and 6*gamma for the second and third differences.
      d1_q    <= (d1_q << (2*StepW)) + (d2_q << StepW);
      src_g_q <= (d3_q << 2) + (d3_q << 1);
    end else if (ctrl_i.fin2) begin
      d1_q <= d1_q + d3_q;
      d2_q <= (d2_q << (StepW + 1)) + src_g_q;
      d3_q <= src_g_q;
    end else if (ctrl_i.advance) begin
      s_q  <= s_q + d1_q;
      d1_q <= d1_q + d2_q;
      d2_q <= d2_q + d3_q;
    end
  end

  assign pos_o = s_q[W-1 -: HELD_BITS];

endmodule

/* design/cbps_back.sv */
// Execution side: holds the control points, sets up each segment and emits its samples.
module cbps_back #(
  parameter int HELD_BITS   = 32,
  parameter int MAX_SAMPLES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  cbps_pkg::kind_e             q_kind_i,
  input  logic [3*HELD_BITS-1:0]      q_point_i,
  input  logic [cbps_pkg::StepW-1:0]  q_step_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [cbps_pkg::TdataW-1:0] m_tdata_o,
  output logic                        m_tlast_o
);
  import cbps_pkg::*;

  localparam int KW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int BitW = $clog2(StepW);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StFin1 = 3'd3;
  localparam logic [2:0] StFin2 = 3'd4;
  localparam logic [2:0] StRun  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [StepW-1:0]            step_q, nstep_q;
  logic [BitW-1:0]             bit_q;
  logic [1:0]                  pass_q;
  logic [KW-1:0]               k_q;
  logic [StepW-1:0]            t_q, t_sum;
  logic                        t_carry;
  logic                        last, run_load, q_pop;
  logic                        out_valid_q, last_out_q;
  logic [StepW-1:0]            t_out_q;
  logic signed [CoordW-1:0]    pos_out_q [3];
  logic signed [HELD_BITS-1:0] pa_q [3];
  logic signed [HELD_BITS-1:0] ph1_q [3];
  logic signed [HELD_BITS-1:0] ph2_q [3];
  logic signed [HELD_BITS-1:0] pb_q [3];
  logic signed [HELD_BITS-1:0] pos [3];
  lane_ctrl_t                  ctrl;

  assign {t_carry, t_sum} = {1'b0, t_q} + {1'b0, step_q};
  // The run ends at the cap or once the next parameter would reach 1.0.
  assign last     = (k_q == KW'(MAX_SAMPLES - 1)) || t_carry;
  assign run_load = (state_q == StRun) && (!out_valid_q || m_tready_i);

  always_comb begin
    state_d = state_q;
    q_pop   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop = 1'b1;
          if (q_kind_i == KIND_SEGMENT) begin
            state_d = StPrep;
          end
        end
      end
      StPrep: state_d = StMul;
      StMul: begin
        if (bit_q == '0 && pass_q == PassLast) begin
          state_d = StFin1;
        end
      end
      StFin1: state_d = StFin2;
      StFin2: state_d = StRun;
      StRun: begin
        if (run_load && last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign q_pop_o = q_pop;

  always_comb begin
    ctrl          = '0;
    ctrl.prep     = (state_q == StPrep);
    ctrl.mul      = (state_q == StMul);
    ctrl.pass     = pass_q;
    ctrl.pass_end = (bit_q == '0);
    ctrl.step_bit = step_q[bit_q];
    ctrl.fin1     = (state_q == StFin1);
    ctrl.fin2     = (state_q == StFin2);
    ctrl.advance  = run_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      bit_q       <= '0;
      pass_q      <= PassFirst;
      k_q         <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop && q_kind_i == KIND_ANCHOR) begin
        step_q <= q_step_i;
      end
      if (state_q == StPrep) begin
        bit_q  <= '1;
        pass_q <= PassFirst;
        k_q    <= '0;
        t_q    <= '0;
      end
      if (state_q == StMul) begin
        bit_q <= bit_q - 1'b1;
        if (bit_q == '0) begin
          pass_q <= pass_q + 1'b1;
        end
      end
      if (run_load) begin
        k_q         <= k_q + 1'b1;
        t_q         <= t_sum;
        out_valid_q <= 1'b1;
        if (last) begin
          step_q <= nstep_q;
        end
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop) begin
      unique case (q_kind_i)
        KIND_ANCHOR: begin
          for (int c = 0; c < 3; c++) pa_q[c] <= q_point_i[c*HELD_BITS +: HELD_BITS];
        end
        KIND_HANDLE1: begin
          for (int c = 0; c < 3; c++) ph1_q[c] <= q_point_i[c*HELD_BITS +: HELD_BITS];
        end
        KIND_HANDLE2: begin
          for (int c = 0; c < 3; c++) ph2_q[c] <= q_point_i[c*HELD_BITS +: HELD_BITS];
        end
        KIND_SEGMENT: begin
          for (int c = 0; c < 3; c++) pb_q[c] <= q_point_i[c*HELD_BITS +: HELD_BITS];
          nstep_q <= q_step_i;
        end
      endcase
    end
    if (run_load) begin
      for (int c = 0; c < 3; c++) pos_out_q[c] <= CoordW'(pos[c]);
      t_out_q    <= t_q;
      last_out_q <= last;
      // The closing anchor becomes the start of the next segment.
      if (last) begin
        for (int c = 0; c < 3; c++) pa_q[c] <= pb_q[c];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    cbps_lane #(
      .HELD_BITS (HELD_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .anchor_i (pa_q[c]),
      .exit_i   (ph1_q[c]),
      .entry_i  (ph2_q[c]),
      .next_i   (pb_q[c]),
      .pos_o    (pos[c])
    );
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {t_out_q, pos_out_q[2], pos_out_q[1], pos_out_q[0]};
  assign m_tlast_o  = last_out_q;

endmodule

/* design/cbps_checker.sv */
// Port-level checks on the sampler's output runs, bound to the top level.
module cbps_checker #(
  parameter int MAX_SAMPLES = cbps_pkg::DefMaxSamples
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cbps_pkg::TdataW-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);
  import cbps_pkg::*;

  localparam int KW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic             out_acc;
  logic             first_q;
  logic [StepW-1:0] prev_t_q, sample_t;
  logic [KW-1:0]    run_cnt_q;

  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign sample_t = m_axis_tdata[TdataW-1 -: StepW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= 1'b1;
      prev_t_q  <= '0;
      run_cnt_q <= '0;
    end else if (out_acc) begin
      first_q   <= m_axis_tlast;
      prev_t_q  <= sample_t;
      run_cnt_q <= m_axis_tlast ? '0 : run_cnt_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_run_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && first_q |-> sample_t == '0)
    else $error("first sample of a run has nonzero parameter");

  a_t_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !first_q |-> sample_t >= prev_t_q)
    else $error("sample parameter went backwards within a run");

  a_run_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && run_cnt_q == KW'(MAX_SAMPLES - 1) |-> m_axis_tlast)
    else $error("run exceeded the sample cap");

endmodule

bind cubic_bezier_path_sampler cbps_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_cbps_checker (.*);

/* sim/cubic_bezier_path_sampler_tb.sv */
// Self-checking testbench for the cubic Bezier path sampler: scripted and random control points.
`timescale 1ns / 1ps

module cubic_bezier_path_sampler_tb;
  import cbps_pkg::*;

  localparam int CoordBits     = 32;
  localparam int MaxSamples    = 64;
  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 4;
  localparam int IdlePct       = 25;
  localparam int NumScripted   = 25;
  localparam int RandomItems   = 296;
  localparam int HoldCycles    = 400;
  localparam int TailCycles    = 150;
  localparam int WatchdogLimit = 2000;

  localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MinNeg = 32'h8000_0000;
  localparam logic [31:0] OneQ   = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] step;
    logic        start;
  } point_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] t;
    logic        last;
  } sample_rec_t;

  // A scripted row; when typed is set, the row's samples are written out by hand:
  // n samples at (ex, ey, ez) with the parameter advancing by dt.
  typedef struct packed {
    point_t      pt;
    logic        typed;
    logic [6:0]  n;
    logic [15:0] dt;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
  } script_row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  // Predictor state: anchor, exit handle and entry handle, each x, y, z.
  logic [31:0] ctrl_pt [3][3];
  logic [15:0] cur_step;
  kind_e       phase;

  sample_rec_t samples_due [$];
  int          mismatches  = 0;
  int          samples_got = 0;
  int          quiet_cycles = 0;
  bit          calm      = 1'b0;
  bit          hold_req  = 1'b0;

  cubic_bezier_path_sampler #(
    .COORD_BITS (CoordBits),
    .MAX_SAMPLES(MaxSamples)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Exact Bernstein blend in Q0.48 weights, rounded half up to Q16.16.
  function automatic logic [31:0] bezier_blend(input logic [31:0] a, h1, h2, b,
                                               input logic [15:0] t);
    logic [63:0] tt;
    logic [63:0] uu;
    logic [63:0] w [4];
    logic [31:0] p [4];
    logic signed [95:0] acc;
    int i;
    tt = {48'd0, t};
    uu = 64'd65536 - tt;
    w[0] = uu * uu * uu;
    w[1] = 64'd3 * uu * uu * tt;
    w[2] = 64'd3 * uu * tt * tt;
    w[3] = tt * tt * tt;
    p[0] = a;
    p[1] = h1;
    p[2] = h2;
    p[3] = b;
    acc = '0;
    for (i = 0; i < 4; i++) begin
      acc = acc + $signed({32'd0, w[i]}) * $signed({{64{p[i][31]}}, p[i]});
    end
    acc = (acc + (96'sd1 <<< (FracW - 1))) >>> FracW;
    return acc[31:0];
  endfunction

  function automatic int sample_count(input logic [15:0] step);
    int n;
    if (step == 16'd0) begin
      n = MaxSamples;
    end else begin
      n = (65536 + int'(step) - 1) / int'(step);
    end
    return (n > MaxSamples) ? MaxSamples : n;
  endfunction

  // Advances the predictor by one accepted point; queues the samples when keep is set.
  task automatic take_point(input point_t pt, input bit keep);
    int          n;
    int          k;
    logic [31:0] prod;
    sample_rec_t s;
    if (pt.start) begin
      ctrl_pt[0] = '{pt.x, pt.y, pt.z};
      cur_step = pt.step;
      phase = KIND_HANDLE1;
    end else begin
      case (phase)
        KIND_ANCHOR: begin
          // No path yet, so the point is dropped.
        end
        KIND_HANDLE1: begin
          ctrl_pt[1] = '{pt.x, pt.y, pt.z};
          phase = KIND_HANDLE2;
        end
        KIND_HANDLE2: begin
          ctrl_pt[2] = '{pt.x, pt.y, pt.z};
          phase = KIND_SEGMENT;
        end
        default: begin
          n = sample_count(cur_step);
          for (k = 0; k < n; k++) begin
            prod = k * cur_step;
            s.t = prod[15:0];
            s.x = bezier_blend(ctrl_pt[0][0], ctrl_pt[1][0], ctrl_pt[2][0], pt.x, s.t);
            s.y = bezier_blend(ctrl_pt[0][1], ctrl_pt[1][1], ctrl_pt[2][1], pt.y, s.t);
            s.z = bezier_blend(ctrl_pt[0][2], ctrl_pt[1][2], ctrl_pt[2][2], pt.z, s.t);
            s.last = (k == n - 1);
            if (keep) samples_due.insert(samples_due.size(), s);
          end
          ctrl_pt[0] = '{pt.x, pt.y, pt.z};
          cur_step = pt.step;
          phase = KIND_HANDLE1;
        end
      endcase
    end
  endtask

  function automatic script_row_t entry(input logic start, input logic [31:0] x, y, z,
                                        input logic [15:0] step, input logic typed,
                                        input logic [6:0] n, input logic [15:0] dt,
                                        input logic [31:0] ex, ey, ez);
    script_row_t r;
    r.pt = '{x: x, y: y, z: z, step: step, start: start};
    r.typed = typed;
    r.n = n;
    r.dt = dt;
    r.ex = ex;
    r.ey = ey;
    r.ez = ez;
    return r;
  endfunction

  // Scripted path: stray point, constant segments, zero and tiny steps, dropped segments.
  function automatic script_row_t script_row(input int idx);
    script_row_t r;
    case (idx)
      // A point before any path start is ignored.
      0:  r = entry(0, 32'h1234_5678, 0, 1, 16'h4000, 1, 0, 0, 0, 0, 0);
      1:  r = entry(1, MaxPos, MinNeg, OneQ, 16'h4000, 1, 0, 0, 0, 0, 0);
      2:  r = entry(0, MaxPos, MinNeg, OneQ, 16'h0000, 0, 0, 0, 0, 0, 0);
      3:  r = entry(0, MaxPos, MinNeg, OneQ, 16'hFFFF, 0, 0, 0, 0, 0, 0);
      // All four points equal: every sample sits on that point.
      4:  r = entry(0, MaxPos, MinNeg, OneQ, 16'hFFFF, 1, 4, 16'h4000, MaxPos, MinNeg, OneQ);
      5:  r = entry(0, MinNeg, MaxPos, 32'hFFFF_FFFF, 16'h0000, 0, 0, 0, 0, 0, 0);
      6:  r = entry(0, MinNeg, MaxPos, 32'hFFFF_FFFF, 16'h5555, 0, 0, 0, 0, 0, 0);
      7:  r = entry(0, MaxPos, MinNeg, OneQ, 16'h0000, 0, 0, 0, 0, 0, 0);
      8:  r = entry(0, MinNeg, MaxPos, 32'hFFFF_FFFF, 16'hAAAA, 0, 0, 0, 0, 0, 0);
      9:  r = entry(0, MaxPos, MaxPos, MaxPos, 16'h0000, 0, 0, 0, 0, 0, 0);
      // A zero step repeats t = 0 for the full run, so every sample is the anchor.
      10: r = entry(0, MinNeg, MinNeg, MinNeg, 16'h0001, 1, 64, 16'h0000, MaxPos, MinNeg, OneQ);
      11: r = entry(0, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_8000, 16'h8000, 0, 0, 0, 0, 0, 0);
      12: r = entry(0, 32'h7FFF_8000, 32'h8000_8000, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
      13: r = entry(0, 1, 32'hFFFF_FFFF, 32'h5555_5555, 16'd1023, 0, 0, 0, 0, 0, 0);
      14: r = entry(0, 32'h2AAA_AAAA, 32'hD555_5555, 32'h0000_0001, 16'h1234, 0, 0, 0, 0, 0, 0);
      // A path start in the middle of a segment drops it.
      15: r = entry(1, 32'h0101_0101, 32'hF0F0_F0F0, 32'h8000_0001, 16'h8000, 1, 0, 0, 0, 0, 0);
      16: r = entry(0, 32'h0F0F_0F0F, MaxPos, MinNeg, 16'h0400, 0, 0, 0, 0, 0, 0);
      17: r = entry(0, MinNeg, 32'h0000_0002, MaxPos, 16'h0400, 0, 0, 0, 0, 0, 0);
      18: r = entry(1, 0, 0, 0, 16'h8000, 1, 0, 0, 0, 0, 0);
      19: r = entry(0, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
      20: r = entry(0, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
      21: r = entry(0, 0, 0, 0, 16'hFFFF, 1, 2, 16'h8000, 0, 0, 0);
      22: r = entry(0, MaxPos, MaxPos, MaxPos, 16'h0000, 0, 0, 0, 0, 0, 0);
      23: r = entry(0, MinNeg, MinNeg, MinNeg, 16'h0000, 0, 0, 0, 0, 0, 0);
      default: r = entry(0, MaxPos, MinNeg, MaxPos, 16'd1024, 0, 0, 0, 0, 0, 0);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = MaxPos;
      1:       v = MinNeg;
      2:       v = 32'd0;
      3:       v = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_step();
    logic [15:0] v;
    case ($urandom_range(19))
      0:       v = 16'($urandom_range(1023));
      1:       v = 16'd1024;
      2:       v = 16'hFFFF;
      default: v = 16'($urandom_range(65535, 4096));
    endcase
    return v;
  endfunction

  // Offers one point, idling at random first, and returns at the edge where it is taken.
  task automatic send_point(input point_t pt);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pt.step, pt.z, pt.y, pt.x};
    s_axis_tuser  <= pt.start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 50) begin
      $display("sample %0d: %s got %h, want %h", samples_got, field, got, want);
    end
    mismatches++;
  endtask

  initial begin : stimulus
    script_row_t r;
    point_t      pt;
    sample_rec_t s;
    int          i;
    int          k;
    logic [31:0] prod;
    phase = KIND_ANCHOR;
    cur_step = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumScripted; i++) begin
      r = script_row(i);
      send_point(r.pt);
      take_point(r.pt, !r.typed);
      if (r.typed) begin
        for (k = 0; k < int'(r.n); k++) begin
          prod = k * r.dt;
          s = '{x: r.ex, y: r.ey, z: r.ez, t: prod[15:0], last: (k == int'(r.n) - 1)};
          samples_due.insert(samples_due.size(), s);
        end
      end
    end

    // Mostly well-formed segments with random content; now and then a path restarts.
    for (i = 0; i < RandomItems; i++) begin
      calm = (i >= 120 && i < 200);
      if (i == 40) hold_req = 1'b1;
      pt.x = rand_coord();
      pt.y = rand_coord();
      pt.z = rand_coord();
      pt.step = rand_step();
      pt.start = (i == 0) || ($urandom_range(11) == 0);
      send_point(pt);
      take_point(pt, 1'b1);
    end
    s_axis_tvalid <= 1'b0;

    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("cubic_bezier_path_sampler_tb: clean");
    end else begin
      $display("cubic_bezier_path_sampler_tb: errors");
    end
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off so the input stalls.
  initial begin : sample_sink
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin : sample_check
    sample_rec_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (samples_due.size() == 0) begin
        note_mismatch("unexpected sample, pos_x", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = samples_due.pop_front();
        if (m_axis_tdata[31:0] !== want.x) note_mismatch("pos_x", m_axis_tdata[31:0], want.x);
        if (m_axis_tdata[63:32] !== want.y) note_mismatch("pos_y", m_axis_tdata[63:32], want.y);
        if (m_axis_tdata[95:64] !== want.z) note_mismatch("pos_z", m_axis_tdata[95:64], want.z);
        if (m_axis_tdata[111:96] !== want.t) begin
          note_mismatch("sample_t", {16'd0, m_axis_tdata[111:96]}, {16'd0, want.t});
        end
        if (m_axis_tlast !== want.last) begin
          note_mismatch("last_sample", {31'd0, m_axis_tlast}, {31'd0, want.last});
        end
      end
      samples_got++;
    end
  end

  // Ends a hung run: counts cycles in which no transaction happens on either side.
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("no transaction for %0d cycles, %0d samples outstanding",
                 quiet_cycles, samples_due.size());
        $display("cubic_bezier_path_sampler_tb: errors");
        $finish;
      end
    end
  end

endmodule
